### hdl/ads_pkg.sv
// ----------------------------------------------------------------------------
// ads_pkg
// Shared types and constants for the altitude drop release sequencer:
// configuration bundle, controller/datapath command and status groups,
// stage codes, register indexes and unit conversion factors.
// ----------------------------------------------------------------------------
package ads_pkg;

    // Widths of the fixed item fields
    localparam int TIME_W   = 32;
    localparam int ALT_W    = 24;
    localparam int THR_W    = 16;
    localparam int PULSE_W  = 12;
    localparam int STAGE_W  = 2;
    localparam int CFG_W    = 16;
    localparam int CFGIDX_W = 3;

    // Arm and drop hold targets in microseconds
    localparam int ARM_TGT_W  = 28;
    localparam int DROP_TGT_W = 26;

    // Divider: blink period is below 2^22 us, 1e6 / hz is below 2^20
    localparam int DIVR_W     = 22;
    localparam int CNT_W      = 5;
    localparam int QPER_W     = 20;
    localparam logic [CNT_W-1:0] PER_TOP_BIT = 5'd19;
    localparam logic [CNT_W-1:0] MOD_TOP_BIT = 5'd31;

    // Unit conversions
    localparam logic [TIME_W-1:0]     US_PER_S  = 32'd1000000;
    localparam logic [DROP_TGT_W-1:0] US_PER_MS = 26'd1000;
    localparam logic signed [ALT_W-1:0] CM_PER_M = 24'sd100;

    // Stage codes
    localparam logic [STAGE_W-1:0] STG_WAIT  = 2'd0;
    localparam logic [STAGE_W-1:0] STG_ARMED = 2'd1;
    localparam logic [STAGE_W-1:0] STG_TRIG  = 2'd2;

    // Configuration register indexes
    localparam logic [CFGIDX_W-1:0] REG_DROP_EN  = 3'd0;
    localparam logic [CFGIDX_W-1:0] REG_IND_EN   = 3'd1;
    localparam logic [CFGIDX_W-1:0] REG_THRESH   = 3'd2;
    localparam logic [CFGIDX_W-1:0] REG_DROP_MS  = 3'd3;
    localparam logic [CFGIDX_W-1:0] REG_ARM_S    = 3'd4;
    localparam logic [CFGIDX_W-1:0] REG_BLINK_HZ = 3'd5;

    // Register reset values
    localparam logic [15:0] DROP_MS_RST  = 16'd25;
    localparam logic [7:0]  ARM_S_RST    = 8'd1;
    localparam logic [7:0]  BLINK_HZ_RST = 8'd5;

    // Divider operand select
    localparam logic DIV_PERIOD = 1'b0;
    localparam logic DIV_MOD    = 1'b1;

    typedef struct packed {
        logic        drop_enabled;
        logic        indicator_enabled;
        logic [15:0] threshold_m;
        logic [15:0] drop_hold_ms;
        logic [7:0]  arm_hold_s;
        logic [7:0]  blink_hz;
    } ads_cfg_t;

    typedef struct packed {
        logic capture;     // latch the accepted request
        logic calc;        // register threshold and hold targets
        logic update;      // commit stage and hold timers
        logic div_start;   // launch the shared divider
        logic div_sel;     // DIV_PERIOD or DIV_MOD
        logic lamp_load;   // take blink phase from the remainder
        logic out_load;    // move the result into the output register
    } ads_cmd_t;

    typedef struct packed {
        logic need_lamp;   // blink phase must be computed
        logic div_done;    // divider finished this cycle
        logic out_free;    // output register can take a result
    } ads_sts_t;

endpackage

### hdl/ads_div.sv
// ----------------------------------------------------------------------------
// ads_div
// Restoring divider, one dividend bit per cycle, starting at a chosen top
// bit. Gives quotient and remainder and a one-cycle done pulse.
// ----------------------------------------------------------------------------
module ads_div
    import ads_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [DIVR_W-1:0] divisor,
    input  logic [CNT_W-1:0]  top_bit,
    output logic [TIME_W-1:0] quotient,
    output logic [DIVR_W-1:0] remainder,
    output logic              done
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [TIME_W-1:0] dvd_reg;
    logic [DIVR_W-1:0] dsr_reg;
    logic [TIME_W-1:0] quo_reg;
    logic [DIVR_W-1:0] rem_reg;

    logic [DIVR_W:0]   trial;
    logic              ge;
    logic [DIVR_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[cnt_reg]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= top_bit;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[TIME_W-2:0], ge};
            rem_reg <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

### hdl/ads_datapath.sv
// ----------------------------------------------------------------------------
// ads_datapath
// Input capture, threshold and hold target products, stage and hold timer
// state, blink phase through the shared divider, and the output register.
// ----------------------------------------------------------------------------
module ads_datapath
    import ads_pkg::*;
#(
    parameter logic [PULSE_W-1:0] PULSE_LOW  = 12'd1000,
    parameter logic [PULSE_W-1:0] PULSE_HIGH = 12'd2000
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ads_cfg_t          cfg,
    input  ads_cmd_t          cmd,
    output ads_sts_t          sts,
    input  logic [TIME_W-1:0] in_time_us,
    input  logic              in_baro_ready,
    input  logic              in_baro_calibrated,
    input  logic [ALT_W-1:0]  in_altitude_cm,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              servo_write,
    output logic [PULSE_W-1:0] servo_pulse_us,
    output logic              lamp_driven,
    output logic              lamp_on,
    output logic [STAGE_W-1:0] stage,
    output logic              arm_hold_running,
    output logic              drop_hold_running
);

    // Captured request
    logic [TIME_W-1:0]        now_reg;
    logic                     ready_reg;
    logic signed [ALT_W-1:0]  alt_reg;

    // Products
    logic signed [ALT_W-1:0]  thr_cm_reg;
    logic [ARM_TGT_W-1:0]     arm_tgt_reg;
    logic [DROP_TGT_W-1:0]    drop_tgt_reg;
    logic signed [ALT_W-1:0]  thr_ext;

    // Sequencer state
    logic [STAGE_W-1:0]       stage_reg,      stage_next;
    logic                     arm_on_reg,     arm_on_next;
    logic [TIME_W-1:0]        arm_start_reg,  arm_start_next;
    logic                     drop_on_reg,    drop_on_next;
    logic [TIME_W-1:0]        drop_start_reg, drop_start_next;

    // Pending result
    logic                     res_write_reg;
    logic [PULSE_W-1:0]       res_pulse_reg;
    logic                     res_ldrv_reg;
    logic                     res_lamp_reg;
    logic                     need_lamp_reg;
    logic                     quad_reg;
    logic [DIVR_W-1:0]        period_reg;

    // Output register
    logic                     out_valid_reg;
    logic                     o_write_reg;
    logic [PULSE_W-1:0]       o_pulse_reg;
    logic                     o_ldrv_reg;
    logic                     o_lamp_reg;
    logic [STAGE_W-1:0]       o_stage_reg;
    logic                     o_arm_reg;
    logic                     o_drop_reg;

    // Update logic
    logic                     active;
    logic                     above;
    logic [TIME_W-1:0]        d_arm;
    logic [TIME_W-1:0]        d_drop;
    logic                     arm_reached;
    logic                     drop_reached;

    // Divider
    logic [TIME_W-1:0]        div_dividend;
    logic [DIVR_W-1:0]        div_divisor;
    logic [CNT_W-1:0]         div_top;
    logic [TIME_W-1:0]        div_quo;
    logic [DIVR_W-1:0]        div_rem;
    logic                     div_done;
    logic [DIVR_W-1:0]        hz_div;
    logic [DIVR_W-1:0]        period_next;

    assign thr_ext = {{(ALT_W-THR_W){cfg.threshold_m[THR_W-1]}}, cfg.threshold_m};

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg   <= in_time_us;
            ready_reg <= in_baro_ready & in_baro_calibrated;
            alt_reg   <= in_altitude_cm;
        end
        if (cmd.calc)
        begin
            thr_cm_reg   <= thr_ext * CM_PER_M;
            arm_tgt_reg  <= ARM_TGT_W'(ARM_TGT_W'(cfg.arm_hold_s) * ARM_TGT_W'(US_PER_S));
            drop_tgt_reg <= DROP_TGT_W'(DROP_TGT_W'(cfg.drop_hold_ms) * US_PER_MS);
        end
    end

    // Elapsed time counts only while the wrapped difference is non-negative
    assign active       = cfg.drop_enabled & ready_reg;
    assign above        = alt_reg > thr_cm_reg;
    assign d_arm        = now_reg - arm_start_reg;
    assign d_drop       = now_reg - drop_start_reg;
    assign arm_reached  = !d_arm[TIME_W-1]  && (d_arm  >= TIME_W'(arm_tgt_reg));
    assign drop_reached = !d_drop[TIME_W-1] && (d_drop >= TIME_W'(drop_tgt_reg));

    always_comb
    begin
        stage_next      = stage_reg;
        arm_on_next     = arm_on_reg;
        arm_start_next  = arm_start_reg;
        drop_on_next    = drop_on_reg;
        drop_start_next = drop_start_reg;
        if (active)
        begin
            unique case (stage_reg)
                STG_WAIT:
                begin
                    drop_on_next = 1'b0;
                    if (above)
                    begin
                        if (!arm_on_reg)
                        begin
                            arm_on_next    = 1'b1;
                            arm_start_next = now_reg;
                        end
                        else if (arm_reached)
                        begin
                            stage_next  = STG_ARMED;
                            arm_on_next = 1'b0;
                        end
                    end
                    else
                    begin
                        arm_on_next = 1'b0;
                    end
                end
                STG_ARMED:
                begin
                    arm_on_next = 1'b0;
                    if (above)
                    begin
                        drop_on_next = 1'b0;
                    end
                    else if (!drop_on_reg)
                    begin
                        drop_on_next    = 1'b1;
                        drop_start_next = now_reg;
                    end
                    else if (drop_reached)
                    begin
                        stage_next   = STG_TRIG;
                        drop_on_next = 1'b0;
                    end
                end
                default:
                begin
                    arm_on_next  = 1'b0;
                    drop_on_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg      <= STG_WAIT;
            arm_on_reg     <= 1'b0;
            arm_start_reg  <= '0;
            drop_on_reg    <= 1'b0;
            drop_start_reg <= '0;
        end
        else if (cmd.update)
        begin
            stage_reg      <= stage_next;
            arm_on_reg     <= arm_on_next;
            arm_start_reg  <= arm_start_next;
            drop_on_reg    <= drop_on_next;
            drop_start_reg <= drop_start_next;
        end
    end

    // Blink rate zero counts as one hertz; waiting stage blinks four times slower
    assign hz_div      = (cfg.blink_hz == '0) ? DIVR_W'(1) : DIVR_W'(cfg.blink_hz);
    assign period_next = quad_reg ? {div_quo[QPER_W-1:0], 2'b00}
                                  : DIVR_W'(div_quo[QPER_W-1:0]);

    always_comb
    begin
        if (cmd.div_sel == DIV_MOD)
        begin
            div_dividend = now_reg;
            div_divisor  = period_next;
            div_top      = MOD_TOP_BIT;
        end
        else
        begin
            div_dividend = US_PER_S;
            div_divisor  = hz_div;
            div_top      = PER_TOP_BIT;
        end
    end

    ads_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .top_bit   (div_top),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res_write_reg <= cfg.drop_enabled;
            res_pulse_reg <= (active && stage_next == STG_TRIG) ? PULSE_HIGH : PULSE_LOW;
            res_ldrv_reg  <= cfg.indicator_enabled;
            res_lamp_reg  <= cfg.drop_enabled & cfg.indicator_enabled
                             & (stage_next == STG_TRIG);
            need_lamp_reg <= cfg.drop_enabled & cfg.indicator_enabled
                             & (stage_next != STG_TRIG);
            quad_reg      <= (stage_next == STG_WAIT);
        end
        if (cmd.div_start && cmd.div_sel == DIV_MOD)
        begin
            period_reg <= period_next;
        end
        if (cmd.lamp_load)
        begin
            res_lamp_reg <= (div_rem < (period_reg >> 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            o_write_reg <= res_write_reg;
            o_pulse_reg <= res_pulse_reg;
            o_ldrv_reg  <= res_ldrv_reg;
            o_lamp_reg  <= res_lamp_reg;
            o_stage_reg <= stage_reg;
            o_arm_reg   <= arm_on_reg;
            o_drop_reg  <= drop_on_reg;
        end
    end

    assign sts.need_lamp = need_lamp_reg;
    assign sts.div_done  = div_done;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign servo_write       = o_write_reg;
    assign servo_pulse_us    = o_pulse_reg;
    assign lamp_driven       = o_ldrv_reg;
    assign lamp_on           = o_lamp_reg;
    assign stage             = o_stage_reg;
    assign arm_hold_running  = o_arm_reg;
    assign drop_hold_running = o_drop_reg;

endmodule

### hdl/ads_ctrl.sv
// ----------------------------------------------------------------------------
// ads_ctrl
// Sequencing state machine: accept a request, run the update steps, drive
// the divider when a blink phase is needed, hand the result to the output.
// ----------------------------------------------------------------------------
module ads_ctrl
    import ads_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ads_sts_t sts,
    output ads_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_UPDATE,
        ST_DECIDE,
        ST_PER_WAIT,
        ST_MOD_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.capture = 1'b1;
                    ready_next  = 1'b0;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.need_lamp)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_PERIOD;
                    state_next    = ST_PER_WAIT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PER_WAIT:
            begin
                cmd.div_sel = DIV_MOD;
                if (sts.div_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_MOD_WAIT;
                end
            end
            ST_MOD_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.lamp_load = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    ready_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

### hdl/altitude_drop_release_sequencer.sv
// ----------------------------------------------------------------------------
// altitude_drop_release_sequencer
// Arms above an altitude threshold, triggers a latched release after a hold
// below it, and drives the servo pulse and indicator lamp for each tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each update tick arrives as one request on the s_axis channel (timestamp,
//   barometer flags, altitude in cm) and yields exactly one result on the
//   m_axis channel (servo write and pulse, lamp, stage, hold timer flags).
//   The user must write registers on the cfg port only while no request is in
//   flight; the block itself does not enforce this. When no blink phase is
//   needed (disabled, lamp not configured, or triggered), an accepted request
//   passes through the calc, update, decide and finish states and its result
//   is then loaded into the output register. Otherwise the shared serial
//   divider runs twice, 1e6 / blink_hz then time_us mod period, before the
//   finish state. The divider sets the rate; one request is in flight at a
//   time. The result sits in an output register, so s_axis_tready returns as
//   soon as the result is loaded even if m_axis stalls; a further finished
//   result waits until the register drains.
//   Reset: stage waiting above threshold, hold timers off, registers at
//   their defaults (disabled, lamp off, threshold 0 m, 25 ms, 1 s, 5 Hz).
// ----------------------------------------------------------------------------
module altitude_drop_release_sequencer
    import ads_pkg::*;
#(
    parameter logic [11:0] PULSE_LOW  = 12'd1000,
    parameter logic [11:0] PULSE_HIGH = 12'd2000
)
(
    input  logic                clk,
    input  logic                rst_n,
    // cfg write port
    input  logic                cfg_we,
    input  logic [CFGIDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    // request channel
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [31:0] time_us, [32] baro_ready, [33] baro_calibrated,
    // [57:34] altitude_cm, [63:58] zero
    input  logic [63:0]         s_axis_tdata,
    // result channel
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [0] servo_write, [12:1] servo_pulse_us, [13] lamp_driven, [14] lamp_on,
    // [16:15] stage, [17] arm_hold_running, [18] drop_hold_running, [23:19] zero
    output logic [23:0]         m_axis_tdata
);

    ads_cfg_t cfg_reg;
    ads_cmd_t cmd;
    ads_sts_t sts;

    logic               servo_write;
    logic [PULSE_W-1:0] servo_pulse_us;
    logic               lamp_driven;
    logic               lamp_on;
    logic [STAGE_W-1:0] stage;
    logic               arm_hold_running;
    logic               drop_hold_running;

    // Register file: writes to unused indexes drop silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drop_enabled      <= 1'b0;
            cfg_reg.indicator_enabled <= 1'b0;
            cfg_reg.threshold_m       <= '0;
            cfg_reg.drop_hold_ms      <= DROP_MS_RST;
            cfg_reg.arm_hold_s        <= ARM_S_RST;
            cfg_reg.blink_hz          <= BLINK_HZ_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DROP_EN:  cfg_reg.drop_enabled      <= cfg_data[0];
                REG_IND_EN:   cfg_reg.indicator_enabled <= cfg_data[0];
                REG_THRESH:   cfg_reg.threshold_m       <= cfg_data;
                REG_DROP_MS:  cfg_reg.drop_hold_ms      <= cfg_data;
                REG_ARM_S:    cfg_reg.arm_hold_s        <= cfg_data[7:0];
                REG_BLINK_HZ: cfg_reg.blink_hz          <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    // Controller owns the sequence, datapath owns the request, state and result values
    ads_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ads_datapath #(
        .PULSE_LOW  (PULSE_LOW),
        .PULSE_HIGH (PULSE_HIGH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg_reg),
        .cmd                (cmd),
        .sts                (sts),
        .in_time_us         (s_axis_tdata[31:0]),
        .in_baro_ready      (s_axis_tdata[32]),
        .in_baro_calibrated (s_axis_tdata[33]),
        .in_altitude_cm     (s_axis_tdata[57:34]),
        .out_ready          (m_axis_tready),
        .out_valid          (m_axis_tvalid),
        .servo_write        (servo_write),
        .servo_pulse_us     (servo_pulse_us),
        .lamp_driven        (lamp_driven),
        .lamp_on            (lamp_on),
        .stage              (stage),
        .arm_hold_running   (arm_hold_running),
        .drop_hold_running  (drop_hold_running)
    );

    // Pack the result fields from the lowest bit up
    assign m_axis_tdata = {5'b0, drop_hold_running, arm_hold_running, stage,
                           lamp_on, lamp_driven, servo_pulse_us, servo_write};

    // Stage code three never reaches the result
    a_stage_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (stage != 2'd3))
        else $error("illegal stage code in result");

    // The two hold timers belong to different stages and never run together
    a_timers_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(arm_hold_running && drop_hold_running))
        else $error("arm and drop hold timers both running");

    // No servo write means the pulse rests at the low value
    a_idle_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !servo_write) |-> (servo_pulse_us == PULSE_LOW))
        else $error("servo pulse not low while servo is not written");

    // A lit lamp is always a driven lamp
    a_lamp_driven: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && lamp_on) |-> lamp_driven)
        else $error("lamp on without being driven");

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the altitude drop release sequencer. A driver feeds
// update-tick requests from a queue, a predictor derives the servo and lamp
// result for every accepted request, and a monitor compares each returned
// result field by field. Register settings change between traffic phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_top
    import ads_pkg::*;
();

    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 8;
    localparam int          SETTLE_CYCLES  = 80;
    localparam int          RX_HOLD_CYCLES = 600;
    localparam int unsigned CYCLE_LIMIT    = 1000000;

    localparam logic [11:0] PULSE_LOW_US  = 12'd1000;
    localparam logic [11:0] PULSE_HIGH_US = 12'd2000;
    localparam logic [31:0] US_PER_SEC    = 32'd1000000;
    localparam logic [31:0] US_PER_MSEC   = 32'd1000;
    localparam logic [31:0] WAIT_SLOWDOWN = 32'd4;

    // One update tick, packed exactly as it sits in s_axis_tdata[57:0]
    typedef struct packed {
        logic [23:0] altitude_cm;
        logic        baro_calibrated;
        logic        baro_ready;
        logic [31:0] time_us;
    } ads_tick_t;

    // One result, packed exactly as it sits in m_axis_tdata[18:0]
    typedef struct packed {
        logic        drop_hold_running;
        logic        arm_hold_running;
        logic [1:0]  stage;
        logic        lamp_on;
        logic        lamp_driven;
        logic [11:0] servo_pulse_us;
        logic        servo_write;
    } ads_out_t;

    // Sequencer state: stage plus the two hold timers
    typedef struct packed {
        logic [1:0]  stage;
        logic        arm_on;
        logic [31:0] arm_start;
        logic        drop_on;
        logic [31:0] drop_start;
    } flight_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [CFGIDX_W-1:0] cfg_index     = '0;
    logic [CFG_W-1:0]    cfg_data      = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;

    // Register image and live state as the block should hold them
    ads_cfg_t    live_cfg;
    flight_t     live_state;
    // Planning copy used by the stimulus generator to aim at timer edges
    flight_t     plan_state;
    logic [31:0] gen_now;

    ads_tick_t   pending_ticks[$];
    ads_out_t    predicted_outputs[$];
    ads_tick_t   offered_tick;

    int unsigned tx_gap_pct = 0;
    int unsigned rx_gap_pct = 0;
    int unsigned tx_gap     = 0;
    int unsigned rx_gap     = 0;
    int unsigned rx_hold    = 0;
    int          hold_ask   = 0;
    int          hold_seen  = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt    = 0;

    altitude_drop_release_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Elapsed time is read as signed: a negative span never reaches the target
    function automatic logic hold_done(input logic [31:0] now_us,
                                       input logic [31:0] since_us,
                                       input logic [31:0] target_us);
        logic [31:0] span;
        span = now_us - since_us;
        return !span[31] && (span >= target_us);
    endfunction

    // Advance the sequencer by one tick and return the result it produces
    function automatic ads_out_t step_release(inout flight_t st,
                                              input ads_cfg_t c,
                                              input ads_tick_t t);
        ads_out_t           o;
        logic signed [31:0] alt_cm;
        logic signed [31:0] thr_cm;
        logic [31:0]        hz;
        logic [31:0]        period;
        logic               above;
        o = '0;
        o.servo_pulse_us = PULSE_LOW_US;
        if (c.drop_enabled)
        begin
            o.servo_write = 1'b1;
            // Barometer not usable: keep the low pulse and freeze the state
            if (t.baro_ready && t.baro_calibrated)
            begin
                alt_cm = 32'($signed(t.altitude_cm));
                thr_cm = 32'($signed(c.threshold_m)) * 32'sd100;
                above  = (alt_cm > thr_cm);
                case (st.stage)
                    STG_WAIT:
                    begin
                        st.drop_on = 1'b0;
                        if (!above)
                            st.arm_on = 1'b0;
                        else if (!st.arm_on)
                        begin
                            st.arm_on    = 1'b1;
                            st.arm_start = t.time_us;
                        end
                        else if (hold_done(t.time_us, st.arm_start,
                                           32'(c.arm_hold_s) * US_PER_SEC))
                        begin
                            st.stage  = STG_ARMED;
                            st.arm_on = 1'b0;
                        end
                    end
                    STG_ARMED:
                    begin
                        st.arm_on = 1'b0;
                        if (above)
                            st.drop_on = 1'b0;
                        else if (!st.drop_on)
                        begin
                            st.drop_on    = 1'b1;
                            st.drop_start = t.time_us;
                        end
                        else if (hold_done(t.time_us, st.drop_start,
                                           32'(c.drop_hold_ms) * US_PER_MSEC))
                        begin
                            st.stage   = STG_TRIG;
                            st.drop_on = 1'b0;
                        end
                    end
                    default:
                    begin
                        st.arm_on  = 1'b0;
                        st.drop_on = 1'b0;
                    end
                endcase
                o.servo_pulse_us = (st.stage == STG_TRIG) ? PULSE_HIGH_US : PULSE_LOW_US;
            end
            // Lamp: steady once triggered, else blink; a zero rate counts as 1 Hz
            if (st.stage == STG_TRIG)
                o.lamp_on = 1'b1;
            else
            begin
                hz     = (c.blink_hz == 8'd0) ? 32'd1 : 32'(c.blink_hz);
                period = US_PER_SEC / hz;
                if (st.stage == STG_WAIT)
                    period = period * WAIT_SLOWDOWN;
                o.lamp_on = ((t.time_us % period) < (period >> 1));
            end
        end
        o.lamp_driven       = c.indicator_enabled;
        o.lamp_on           = o.lamp_on & c.indicator_enabled;
        o.stage             = st.stage;
        o.arm_hold_running  = st.arm_on;
        o.drop_hold_running = st.drop_on;
        return o;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: hold each request until taken, insert random gaps
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        logic offer;
        if (rst_n)
        begin
            offer = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_outputs.push_back(step_release(live_state, live_cfg, offered_tick));
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (tx_gap != 0)
                    tx_gap--;
                else if (pending_ticks.size() != 0)
                begin
                    // An idle gap of random length may come before the next request
                    if ($urandom_range(0, 99) < tx_gap_pct)
                        tx_gap = $urandom_range(0, 16);
                    else
                    begin
                        offered_tick = pending_ticks.pop_front();
                        offer        = 1'b1;
                    end
                end
            end
            s_axis_tvalid <= offer;
            s_axis_tdata  <= {6'b0, offered_tick};
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare against the oldest prediction, stall at random
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        ads_out_t got;
        ads_out_t want;
        logic     take;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = ads_out_t'(m_axis_tdata[18:0]);
                if (predicted_outputs.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_axis_tdata);
                    mismatch_cnt++;
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    check_field("servo_write", 32'(want.servo_write), 32'(got.servo_write));
                    check_field("servo_pulse_us", 32'(want.servo_pulse_us),
                                32'(got.servo_pulse_us));
                    check_field("lamp_driven", 32'(want.lamp_driven), 32'(got.lamp_driven));
                    check_field("lamp_on", 32'(want.lamp_on), 32'(got.lamp_on));
                    check_field("stage", 32'(want.stage), 32'(got.stage));
                    check_field("arm_hold_running", 32'(want.arm_hold_running),
                                32'(got.arm_hold_running));
                    check_field("drop_hold_running", 32'(want.drop_hold_running),
                                32'(got.drop_hold_running));
                end
            end
            // A new hold-off request starts a long stretch with ready low
            if (hold_seen != hold_ask)
            begin
                hold_seen = hold_ask;
                rx_hold   = RX_HOLD_CYCLES;
            end
            if (rx_hold != 0)
            begin
                rx_hold--;
                take = 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap--;
                take = 1'b0;
            end
            else if ($urandom_range(0, 99) < rx_gap_pct)
            begin
                rx_gap = $urandom_range(0, 16);
                take   = 1'b0;
            end
            else
                take = 1'b1;
            m_axis_tready <= take;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Write one register and mirror it in the predictor's register image
    task automatic set_reg(input logic [CFGIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DROP_EN:  live_cfg.drop_enabled      = val[0];
            REG_IND_EN:   live_cfg.indicator_enabled = val[0];
            REG_THRESH:   live_cfg.threshold_m       = val;
            REG_DROP_MS:  live_cfg.drop_hold_ms      = val;
            REG_ARM_S:    live_cfg.arm_hold_s        = val[7:0];
            REG_BLINK_HZ: live_cfg.blink_hz          = val[7:0];
            default: ;
        endcase
    endtask

    // Hold until every queued request is taken and every result is back;
    // sample between edges so the driver and monitor have settled
    task automatic wait_drained();
        while (pending_ticks.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_tick(input logic [31:0] t_us, input logic rdy, input logic cal,
                              input logic [23:0] alt);
        ads_tick_t t;
        t.time_us         = t_us;
        t.baro_ready      = rdy;
        t.baro_calibrated = cal;
        t.altitude_cm     = alt;
        pending_ticks.push_back(t);
    endtask

    // Queue a flight profile: altitude hovers around the threshold, time mostly
    // advances and often lands right on a running timer's target. Steps that
    // would carry the stage beyond stage_cap are turned back by the altitude.
    task automatic queue_flight(input int n, input logic [1:0] stage_cap);
        ads_tick_t          t;
        flight_t            probe;
        logic signed [31:0] thr_cm;
        logic [31:0]        tgt;
        logic [31:0]        since;
        logic               running;
        logic               up;
        int unsigned        pick;
        thr_cm     = 32'($signed(live_cfg.threshold_m)) * 32'sd100;
        plan_state = live_state;
        for (int i = 0; i < n; i++)
        begin
            t.baro_ready      = ($urandom_range(0, 9) != 0) || ($urandom_range(0, 1) != 0);
            t.baro_calibrated = ($urandom_range(0, 9) != 0) || ($urandom_range(0, 1) != 0);
            // Favor the side that moves the stage on
            if (plan_state.stage == STG_WAIT)
                up = ($urandom_range(0, 4) != 0);
            else
                up = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                t.altitude_cm = 24'($urandom);
            else if (up)
                t.altitude_cm = 24'(thr_cm + 32'($urandom_range(1, 6)));
            else
                t.altitude_cm = 24'(thr_cm - 32'($urandom_range(0, 5)));
            if (plan_state.stage == STG_WAIT)
            begin
                running = plan_state.arm_on;
                since   = plan_state.arm_start;
                tgt     = 32'(live_cfg.arm_hold_s) * US_PER_SEC;
            end
            else
            begin
                running = (plan_state.stage == STG_ARMED) && plan_state.drop_on;
                since   = plan_state.drop_start;
                tgt     = 32'(live_cfg.drop_hold_ms) * US_PER_MSEC;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                gen_now = $urandom;
            else if (running && pick < 40)
                gen_now = since + tgt + $urandom_range(0, 2) - 32'd1;
            else
                gen_now = gen_now + $urandom_range(0, tgt / 3 + 2000);
            t.time_us = gen_now;
            probe = plan_state;
            void'(step_release(probe, live_cfg, t));
            if (probe.stage > stage_cap)
            begin
                // Drop below to restart arming, or climb above to cancel the drop
                if (plan_state.stage == STG_WAIT)
                    t.altitude_cm = 24'(thr_cm);
                else
                    t.altitude_cm = 24'(thr_cm + 32'sd1);
                probe = plan_state;
                void'(step_release(probe, live_cfg, t));
            end
            plan_state = probe;
            pending_ticks.push_back(t);
        end
    endtask

    // Run one traffic phase with the given idle rates, then wait for quiet
    task automatic fly(input int n, input logic [1:0] stage_cap,
                       input int unsigned tx_pct, input int unsigned rx_pct);
        tx_gap_pct <= tx_pct;
        rx_gap_pct <= rx_pct;
        @(negedge clk);
        queue_flight(n, stage_cap);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : run_flights
        live_cfg                   = '0;
        live_cfg.drop_hold_ms      = DROP_MS_RST;
        live_cfg.arm_hold_s        = ARM_S_RST;
        live_cfg.blink_hz          = BLINK_HZ_RST;
        live_state                 = '0;
        gen_now                    = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Disabled, lamp not configured: field extremes
        @(negedge clk);
        queue_tick(32'h0000_0000, 1'b0, 1'b0, 24'h80_0000);
        queue_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 24'h7F_FFFF);
        wait_drained();

        // Lamp configured with a zero blink rate, still disabled
        set_reg(REG_IND_EN, 16'd1);
        set_reg(REG_BLINK_HZ, 16'd0);
        @(negedge clk);
        queue_tick(32'd123456, 1'b1, 1'b1, 24'd0);
        wait_drained();

        // Enabled, lowest threshold, zero arm hold
        set_reg(REG_DROP_EN, 16'd1);
        set_reg(REG_THRESH, 16'h8000);
        set_reg(REG_ARM_S, 16'd0);
        @(negedge clk);
        queue_tick(32'd1500000, 1'b0, 1'b1, 24'h7F_FFFF);        // baro not ready
        queue_tick(32'd2500000, 1'b1, 1'b0, 24'h7F_FFFF);        // not calibrated
        queue_tick(32'd1000, 1'b1, 1'b1, 24'(-32'sd3276800));     // exactly at threshold
        queue_tick(32'd1000, 1'b1, 1'b1, 24'(-32'sd3276799));     // just above: timer starts
        queue_tick(32'd999, 1'b1, 1'b1, 24'(-32'sd3276799));      // time went back
        queue_tick(32'd2000, 1'b1, 1'b0, 24'(-32'sd3276799));     // frozen while not ready
        queue_tick(32'd3000, 1'b1, 1'b1, 24'h80_0000);            // lowest altitude clears timer
        wait_drained();

        // Waiting stage only: arm timers start and restart
        set_reg(REG_ARM_S, 16'd1);
        set_reg(REG_THRESH, 16'($urandom));
        set_reg(REG_BLINK_HZ, 16'd5);
        gen_now = $urandom_range(0, 999);
        fly(150, STG_WAIT, 20, 20);

        // Longest arm hold across the time wrap; the receiver holds off for a
        // long stretch while requests keep coming, so the block backs up
        set_reg(REG_ARM_S, 16'd255);
        set_reg(REG_THRESH, 16'h7FFF);
        set_reg(REG_BLINK_HZ, 16'd255);
        gen_now = 32'hFFFF_F000;
        hold_ask <= hold_ask + 1;
        fly(100, STG_WAIT, 0, 15);

        // Zero arm hold, no idling on either side
        set_reg(REG_ARM_S, 16'd0);
        set_reg(REG_THRESH, 16'd0);
        fly(80, STG_WAIT, 0, 0);

        // Disabled: servo silent, lamp dark, state frozen
        set_reg(REG_DROP_EN, 16'd0);
        set_reg(REG_BLINK_HZ, 16'd3);
        fly(60, STG_WAIT, 30, 30);

        // Arm, then hover around the threshold with the longest drop hold
        set_reg(REG_DROP_EN, 16'd1);
        set_reg(REG_ARM_S, 16'd1);
        set_reg(REG_THRESH, 16'h8000);
        set_reg(REG_DROP_MS, 16'hFFFF);
        set_reg(REG_BLINK_HZ, 16'($urandom_range(1, 255)));
        gen_now = $urandom;
        fly(200, STG_ARMED, 10, 25);

        // Zero drop hold, lamp not configured, slowest blink
        set_reg(REG_IND_EN, 16'd0);
        set_reg(REG_DROP_MS, 16'd0);
        set_reg(REG_BLINK_HZ, 16'd1);
        fly(150, STG_ARMED, 25, 5);

        // Default drop hold straddling the time wrap
        set_reg(REG_IND_EN, 16'd1);
        set_reg(REG_DROP_MS, 16'd25);
        set_reg(REG_THRESH, 16'($urandom));
        set_reg(REG_BLINK_HZ, 16'($urandom_range(1, 255)));
        gen_now = 32'hFFFF_FFFF - 32'd20000;
        fly(150, STG_ARMED, 15, 15);

        // Final stretch without idling: allow the release to trigger and latch
        set_reg(REG_DROP_MS, 16'd3);
        set_reg(REG_THRESH, 16'd150);
        set_reg(REG_BLINK_HZ, 16'd7);
        fly(200, STG_TRIG, 0, 0);

        // Disable after the release has latched
        set_reg(REG_DROP_EN, 16'd0);
        fly(30, STG_TRIG, 0, 0);

        if (mismatch_cnt == 0 && predicted_outputs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

endmodule
